[rtl/sorted_key_value_table_assert.svh]
// Assertion macros for the sorted key/value table.
`ifndef SORTED_KEY_VALUE_TABLE_ASSERT_SVH
`define SORTED_KEY_VALUE_TABLE_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define SKVT_ASSERT_SAME(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Condition implies consequence in the next cycle.
`define SKVT_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

[rtl/skvt_pkg.sv]
`default_nettype none
package skvt_pkg;
   localparam int TABLE_DEPTH_DEF = 64;
   localparam int KEY_W = 16;
   localparam int VAL_W = 16;
   localparam int STATUS_W = 3;
   localparam int COUNT_OUT_W = 7;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 24;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] STS_INSERTED    = 3'd0;
   localparam logic [STATUS_W-1:0] STS_EXISTS      = 3'd1;
   localparam logic [STATUS_W-1:0] STS_FULL        = 3'd2;
   localparam logic [STATUS_W-1:0] STS_LOOKUP_HIT  = 3'd3;
   localparam logic [STATUS_W-1:0] STS_LOOKUP_MISS = 3'd4;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;
endpackage
`default_nettype wire

[rtl/skvt_ctrl.sv]
`default_nettype none
module skvt_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output skvt_pkg::ctrl_cmd_type cmd
);
   import skvt_pkg::*;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_COMMIT = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd.capture = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

[rtl/skvt_datapath.sv]
`default_nettype none
module skvt_datapath #(
   parameter int TABLE_DEPTH = skvt_pkg::TABLE_DEPTH_DEF
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire skvt_pkg::ctrl_cmd_type            cmd,
   input  wire                                    req_func,
   input  wire signed [skvt_pkg::KEY_W-1:0]       req_key,
   input  wire signed [skvt_pkg::VAL_W-1:0]       req_new_value,
   output logic       [skvt_pkg::STATUS_W-1:0]    rsp_status,
   output logic signed [skvt_pkg::VAL_W-1:0]      rsp_found_value,
   output logic       [skvt_pkg::COUNT_OUT_W-1:0] rsp_entry_count
);
   import skvt_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic signed [KEY_W-1:0] key_ff [TABLE_DEPTH];
   logic signed [VAL_W-1:0] val_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] lt_ff, lt_in;
   logic [TABLE_DEPTH-1:0] eq_ff, eq_in;
   logic [VAL_W-1:0] mval_ff [TABLE_DEPTH];
   logic [VAL_W-1:0] mval_in [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] take_new, take_prev;

   logic func_ff;
   logic signed [KEY_W-1:0] op_key_ff;
   logic signed [VAL_W-1:0] op_val_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [VAL_W-1:0] found_ff, found_in;
   logic [COUNT_OUT_W-1:0] ecount_ff;
   logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

   logic hit, full, do_insert;
   logic [VAL_W-1:0] found_or;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cmp
      logic live;
      assign live = (count_ff > CNT_W'(g));
      assign lt_in[g] = live && (key_ff[g] < req_key);
      assign eq_in[g] = live && (key_ff[g] == req_key);
      assign mval_in[g] = eq_in[g] ? val_ff[g] : '0;
   end

   assign hit = |eq_ff;
   assign full = (count_ff == CNT_W'(TABLE_DEPTH));

   always_comb begin
      found_or = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         found_or = found_or | mval_ff[i];
      end
   end

   always_comb begin
      do_insert = 1'b0;
      found_in = '0;
      if (func_ff == FUNC_LOOKUP) begin
         if (hit) begin
            status_in = STS_LOOKUP_HIT;
            found_in = found_or;
         end else begin
            status_in = STS_LOOKUP_MISS;
         end
      end else if (hit) begin
         status_in = STS_EXISTS;
      end else if (full) begin
         status_in = STS_FULL;
      end else begin
         status_in = STS_INSERTED;
         do_insert = cmd.commit;
      end
   end

   assign count_in = count_ff + CNT_W'(do_insert);
   assign count_ext = {{COUNT_OUT_W{1'b0}}, count_in};

   assign take_new[0] = !lt_ff[0];
   assign take_prev[0] = 1'b0;
   for (genvar g = 1; g < TABLE_DEPTH; g++) begin : g_sel
      assign take_new[g] = !lt_ff[g] && lt_ff[g-1];
      assign take_prev[g] = !lt_ff[g-1];
   end

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (do_insert && take_new[g]) begin
               key_ff[g] <= op_key_ff;
               val_ff[g] <= op_val_ff;
            end
         end
      end else begin : g_rest
         always_ff @(posedge clock) begin
            if (do_insert) begin
               if (take_new[g]) begin
                  key_ff[g] <= op_key_ff;
                  val_ff[g] <= op_val_ff;
               end else if (take_prev[g]) begin
                  key_ff[g] <= key_ff[g-1];
                  val_ff[g] <= val_ff[g-1];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
         mval_ff <= mval_in;
         func_ff <= req_func;
         op_key_ff <= req_key;
         op_val_ff <= req_new_value;
      end
      if (cmd.commit) begin
         status_ff <= status_in;
         found_ff <= found_in;
         ecount_ff <= count_ext[COUNT_OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rsp_status = status_ff;
   assign rsp_found_value = found_ff;
   assign rsp_entry_count = ecount_ff;
endmodule
`default_nettype wire

[rtl/sorted_key_value_table.sv]
// Sorted key/value table built as a chain of compare-and-shift cells.
// A request is captured, then committed to the output; a result still
// waiting on the output holds the commit, and with it the next request.
// One item at a time; the capture cycle registers the
// compares of all cells and the commit cycle shifts the chain in one step.
// Reset clears the entry count and the handshake state; cell contents are kept.
`default_nettype none
module sorted_key_value_table #(
   parameter int TABLE_DEPTH = skvt_pkg::TABLE_DEPTH_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // key [15:0], new_value [31:16]
   input  wire  [skvt_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // func [0]
   input  wire                                 req_tuser,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // found_value [15:0], entry_count [22:16], zero [23]
   output logic [skvt_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // status [2:0]
   output logic [skvt_pkg::STATUS_W-1:0]       rsp_tuser
);
   import skvt_pkg::*;

   ctrl_cmd_type cmd;
   logic [STATUS_W-1:0] status;
   logic signed [VAL_W-1:0] found_value;
   logic [COUNT_OUT_W-1:0] entry_count;

   skvt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   skvt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_func        (req_tuser),
      .req_key         (req_tdata[KEY_W-1:0]),
      .req_new_value   (req_tdata[KEY_W+VAL_W-1:KEY_W]),
      .rsp_status      (status),
      .rsp_found_value (found_value),
      .rsp_entry_count (entry_count)
   );

   assign rsp_tdata = {1'b0, entry_count, found_value};
   assign rsp_tuser = status;

`include "sorted_key_value_table_assert.svh"

   `SKVT_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready,
      "second item taken while busy")
   `SKVT_ASSERT_SAME(a_status_code, clock, reset, rsp_tvalid, rsp_tuser <= STS_LOOKUP_MISS,
      "undefined status code")
   `SKVT_ASSERT_SAME(a_found_zero, clock, reset, rsp_tvalid && (rsp_tuser != STS_LOOKUP_HIT),
      rsp_tdata[VAL_W-1:0] == '0, "value without lookup hit")
   `SKVT_ASSERT_SAME(a_commit_once, clock, reset, cmd.commit, !cmd.capture && !req_tready,
      "commit outside busy phase")
endmodule
`default_nettype wire

[test/sorted_key_value_table_checker.sv]
`default_nettype none
module sorted_key_value_table_checker #(
   parameter int TABLE_DEPTH = skvt_pkg::TABLE_DEPTH_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   input  wire                                 req_tready,
   // key [15:0], new_value [31:16]
   input  wire  [skvt_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // func [0]
   input  wire                                 req_tuser,
   input  wire                                 rsp_tvalid,
   input  wire                                 rsp_tready,
   // found_value [15:0], entry_count [22:16], zero [23]
   input  wire  [skvt_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // status [2:0]
   input  wire  [skvt_pkg::STATUS_W-1:0]       rsp_tuser,
   output int                                  mismatch_count,
   output int                                  outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [skvt_pkg::STATUS_W-1:0]    status;
      logic [skvt_pkg::VAL_W-1:0]       found_value;
      logic [skvt_pkg::COUNT_OUT_W-1:0] entry_count;
   } table_result_type;

   logic signed [skvt_pkg::KEY_W-1:0] key_cells   [TABLE_DEPTH];
   logic signed [skvt_pkg::VAL_W-1:0] value_cells [TABLE_DEPTH];
   int                                table_count;
   table_result_type                  expected_results[$];

   initial begin
      mismatch_count = 0;
      outstanding = 0;
      table_count = 0;
   end

   function automatic table_result_type apply_request(input logic func,
         input logic signed [skvt_pkg::KEY_W-1:0] key,
         input logic signed [skvt_pkg::VAL_W-1:0] value);
      table_result_type res;
      int               pos;
      logic             hit;
      res = '0;
      pos = 0;
      while (pos < table_count && key_cells[pos] < key) pos++;
      hit = (pos < table_count) && (key_cells[pos] == key);
      if (func == skvt_pkg::FUNC_LOOKUP) begin
         if (hit) begin
            res.status = skvt_pkg::STS_LOOKUP_HIT;
            res.found_value = value_cells[pos];
         end else begin
            res.status = skvt_pkg::STS_LOOKUP_MISS;
         end
      end else if (hit) begin
         res.status = skvt_pkg::STS_EXISTS;
      end else if (table_count >= TABLE_DEPTH) begin
         res.status = skvt_pkg::STS_FULL;
      end else begin
         for (int j = table_count; j > pos; j--) begin
            key_cells[j] = key_cells[j-1];
            value_cells[j] = value_cells[j-1];
         end
         key_cells[pos] = key;
         value_cells[pos] = value;
         table_count++;
         res.status = skvt_pkg::STS_INSERTED;
      end
      res.entry_count = skvt_pkg::COUNT_OUT_W'(table_count);
      return res;
   endfunction

   always @(posedge clock) begin
      table_result_type exp;
      if (reset) begin
         table_count = 0;
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("response transfer with no request outstanding");
               mismatch_count++;
            end else begin
               exp = expected_results.pop_front();
               if (rsp_tuser !== exp.status) begin
                  $error("status: expected %0d, got %0d", exp.status, rsp_tuser);
                  mismatch_count++;
               end
               if (rsp_tdata[15:0] !== exp.found_value) begin
                  $error("found_value: expected %0d, got %0d",
                         $signed(exp.found_value), $signed(rsp_tdata[15:0]));
                  mismatch_count++;
               end
               if (rsp_tdata[22:16] !== exp.entry_count) begin
                  $error("entry_count: expected %0d, got %0d", exp.entry_count,
                         rsp_tdata[22:16]);
                  mismatch_count++;
               end
               if (rsp_tdata[23] !== 1'b0) begin
                  $error("rsp_tdata[23]: expected 0, got %b", rsp_tdata[23]);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(apply_request(req_tuser, req_tdata[15:0],
                                                     req_tdata[31:16]));
      end
      outstanding = expected_results.size();
   end
endmodule
`default_nettype wire

[test/sorted_key_value_table_tb.sv]
`default_nettype none
module sorted_key_value_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int ITEMS_PER_PHASE = 212;
   localparam int HOLD_OFF_CYCLES = 150;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_tvalid;
   wire                                  req_tready;
   logic [skvt_pkg::REQ_TDATA_W-1:0]     req_tdata;
   logic                                 req_tuser;
   wire                                  rsp_tvalid;
   logic                                 rsp_tready;
   wire  [skvt_pkg::RSP_TDATA_W-1:0]     rsp_tdata;
   wire  [skvt_pkg::STATUS_W-1:0]        rsp_tuser;

   int                                   mismatch_count;
   int                                   outstanding;
   int                                   cycle_count = 0;
   int                                   sent_total = 0;
   int                                   insert_total = 0;
   int                                   lookup_total = 0;
   int                                   send_idle_pct = 0;
   int                                   recv_stall_pct = 0;
   logic                                 hold_off = 1'b0;
   logic [skvt_pkg::KEY_W-1:0]           used_keys[$];

   sorted_key_value_table i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   sorted_key_value_table_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $error("run exceeded %0d cycles", CYCLE_LIMIT);
      $display("FAIL sorted_key_value_table");
      $finish;
   end

   always @(negedge clock) begin
      if (hold_off)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin
      wait (sent_total >= 40);
      @(negedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(negedge clock);
      hold_off <= 1'b0;
   end

   task automatic send_request(input logic func, input logic [skvt_pkg::KEY_W-1:0] key,
                               input logic [skvt_pkg::VAL_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {value, key};
      do @(posedge clock); while (!req_tready);
      sent_total++;
      if (func == skvt_pkg::FUNC_INSERT) begin
         insert_total++;
         used_keys.push_back(key);
      end else begin
         lookup_total++;
      end
      @(negedge clock);
   endtask

   task automatic random_request();
      int                         sel;
      logic [skvt_pkg::KEY_W-1:0] key;
      sel = $urandom_range(99);
      if (used_keys.size() > 0 && sel < 40)
         key = used_keys[$urandom_range(used_keys.size() - 1)];
      else if (used_keys.size() > 0 && sel < 50)
         key = used_keys[$urandom_range(used_keys.size() - 1)]
               + ($urandom_range(1) ? 16'h0001 : 16'hFFFF);
      else if (sel < 55)
         key = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      else
         key = 16'($urandom());
      send_request($urandom_range(1) ? skvt_pkg::FUNC_LOOKUP : skvt_pkg::FUNC_INSERT,
                   key, 16'($urandom()));
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = skvt_pkg::FUNC_INSERT;
      rsp_tready = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(skvt_pkg::FUNC_LOOKUP, 16'h0000, 16'h0000);
      send_request(skvt_pkg::FUNC_INSERT, 16'h0000, 16'h7FFF);
      send_request(skvt_pkg::FUNC_INSERT, 16'h8000, 16'h8000);
      send_request(skvt_pkg::FUNC_INSERT, 16'h7FFF, 16'hFFFF);
      send_request(skvt_pkg::FUNC_INSERT, 16'hFFFF, 16'h0001);
      send_request(skvt_pkg::FUNC_INSERT, 16'h0001, 16'h5555);
      send_request(skvt_pkg::FUNC_INSERT, 16'h4000, 16'hAAAA);
      send_request(skvt_pkg::FUNC_INSERT, 16'h0000, 16'h1234);
      send_request(skvt_pkg::FUNC_LOOKUP, 16'h8000, 16'hFFFF);
      send_request(skvt_pkg::FUNC_LOOKUP, 16'h7FFF, 16'h0000);
      send_request(skvt_pkg::FUNC_LOOKUP, 16'h0000, 16'hAAAA);
      send_request(skvt_pkg::FUNC_LOOKUP, 16'h0002, 16'h0000);
      send_request(skvt_pkg::FUNC_LOOKUP, 16'hFFFF, 16'h5555);
      send_request(skvt_pkg::FUNC_INSERT, 16'h8000, 16'h0000);
      send_request(skvt_pkg::FUNC_LOOKUP, 16'hFFFE, 16'h0000);
      send_request(skvt_pkg::FUNC_LOOKUP, 16'h4000, 16'h0000);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 87;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 87;
            end
            default: begin
               send_idle_pct = 37;
               recv_stall_pct = 37;
            end
         endcase
         repeat (ITEMS_PER_PHASE) random_request();
      end
      req_tvalid <= 1'b0;

      wait (outstanding == 0);
      repeat (8) @(posedge clock);
      $display("Covered %0d transfers (%0d inserts, %0d lookups) over four pacing phases",
               sent_total, insert_total, lookup_total);
      $display("and a %0d-cycle response hold-off, filling the table to capacity.",
               HOLD_OFF_CYCLES);
      if (mismatch_count == 0)
         $display("PASS sorted_key_value_table");
      else
         $display("FAIL sorted_key_value_table");
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
+incdir+rtl
rtl/skvt_pkg.sv
rtl/skvt_ctrl.sv
rtl/skvt_datapath.sv
rtl/sorted_key_value_table.sv
test/sorted_key_value_table_checker.sv
test/sorted_key_value_table_tb.sv
